// File: hw/rtl/dad_pkg.sv
// shared types, constants and register map for the deauth attack detector
// no dependencies; imported by every module of the block
package dad_pkg;

    // channel plan
    localparam int NUM_CHANNELS = 13;
    localparam int CHAN_W       = 4;

    // frame classification
    localparam logic [15:0] MIN_FRAME_LEN = 16'd28;
    localparam logic [7:0]  TYPE_DEAUTH   = 8'hA0;
    localparam logic [7:0]  TYPE_DISASSOC = 8'hC0;

    // saturation limits
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [7:0]  RUN_MAX   = 8'hFF;

    // configuration register reset values
    localparam logic        ENABLE_RST      = 1'b0;
    localparam logic [15:0] MIN_PACKETS_RST = 16'd5;
    localparam logic [7:0]  MIN_WINDOWS_RST = 8'd1;
    localparam logic [15:0] DWELL_MS_RST    = 16'd140;
    localparam logic [15:0] WINDOW_MS_RST   = 16'(NUM_CHANNELS * 140);

    // configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_ENABLE      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_PACKETS = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_WINDOWS = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DWELL_MS    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_MS   = 3'd4;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic        cmd;
        logic [7:0]  frame_type_byte;
        logic [15:0] frame_length;
    } in_item_t;

    typedef struct packed {
        logic        window_done;
        logic [15:0] window_packet_count;
        logic [7:0]  attack_run;
        logic        attack_onset;
        logic        attack_cleared;
        logic        channel_changed;
        logic [3:0]  channel;
    } out_item_t;

    // classified work entry
    typedef struct packed {
        logic is_tick;
        logic is_match;
    } q_entry_t;

    // current configuration
    typedef struct packed {
        logic        enable;
        logic [15:0] min_packets;
        logic [7:0]  min_windows;
        logic [15:0] dwell_ms;
        logic [15:0] window_ms;
    } cfg_t;

    // queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: hw/rtl/deauth_attack_detector_unit.sv
// top level of the deauth attack detector
// depends on dad_pkg, dad_regs, dad_front, dad_queue and dad_back
//
// Each input transaction is a captured frame (cmd 0) or a one millisecond tick
// (cmd 1) and yields exactly one result transaction. The block takes one
// transaction per clock cycle sustained while it is not stalled. Each result
// is registered twice on its way: the accepting edge writes the two-entry
// classification queue, and a later edge, once the result register is free or
// draining, writes the output register of the counter and timer stage. The
// input is stalled only while that queue is full, which happens when the result
// side stalls. Configuration writes take an APB setup phase and an access phase
// and should be made while no transaction is in flight.
module deauth_attack_detector_unit
    import dad_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t      cfg;
    q_status_t q_status;
    logic      push;
    q_entry_t  push_entry;
    logic      pop;
    q_entry_t  head;

    // configuration registers
    dad_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // accept and classify
    dad_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // decoupling queue
    dad_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // counters, timers and result register
    dad_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// File: hw/rtl/dad_regs.sv
// configuration registers behind the APB-style port
// depends on dad_pkg
module dad_regs
    import dad_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable      <= ENABLE_RST;
            cfg_reg.min_packets <= MIN_PACKETS_RST;
            cfg_reg.min_windows <= MIN_WINDOWS_RST;
            cfg_reg.dwell_ms    <= DWELL_MS_RST;
            cfg_reg.window_ms   <= WINDOW_MS_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ENABLE:      cfg_reg.enable      <= pwdata[0];
                REG_MIN_PACKETS: cfg_reg.min_packets <= pwdata[15:0];
                REG_MIN_WINDOWS: cfg_reg.min_windows <= pwdata[7:0];
                REG_DWELL_MS:    cfg_reg.dwell_ms    <= pwdata[15:0];
                REG_WINDOW_MS:   cfg_reg.window_ms   <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_ENABLE:      prdata = {31'd0, cfg_reg.enable};
            REG_MIN_PACKETS: prdata = {16'd0, cfg_reg.min_packets};
            REG_MIN_WINDOWS: prdata = {24'd0, cfg_reg.min_windows};
            REG_DWELL_MS:    prdata = {16'd0, cfg_reg.dwell_ms};
            REG_WINDOW_MS:   prdata = {16'd0, cfg_reg.window_ms};
            default:         prdata = '0;
        endcase
    end

endmodule

// File: hw/rtl/dad_front.sv
// front end: accepts input transactions and classifies them for the queue
// depends on dad_pkg
module dad_front
    import dad_pkg::*;
(
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    input  q_status_t q_status,
    output logic      push,
    output q_entry_t  push_entry
);

    logic len_ok;
    logic type_ok;

    // hold off the source while the queue is full
    assign in_stall = q_status.full;
    assign push     = in_valid & ~q_status.full;

    // deauthentication or disassociation frame of usable length
    assign len_ok  = (in_item.frame_length >= MIN_FRAME_LEN);
    assign type_ok = (in_item.frame_type_byte == TYPE_DEAUTH) ||
                     (in_item.frame_type_byte == TYPE_DISASSOC);

    assign push_entry.is_tick  = in_item.cmd;
    assign push_entry.is_match = ~in_item.cmd & len_ok & type_ok;

endmodule

// File: hw/rtl/dad_queue.sv
// short fifo of classified entries between front and back
// depends on dad_pkg
module dad_queue
    import dad_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_entry_t  push_entry,
    input  logic      pop,
    output q_entry_t  head,
    output q_status_t status
);

    q_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign status.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: hw/rtl/dad_back.sv
// back end: counters, window and dwell timers, result register
// depends on dad_pkg
module dad_back
    import dad_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  q_entry_t  head,
    input  q_status_t q_status,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    logic [15:0]       pkt_count_reg, pkt_count_next;
    logic [7:0]        run_reg, run_next;
    logic [15:0]       win_elapsed_reg, win_elapsed_next;
    logic [15:0]       dwell_elapsed_reg, dwell_elapsed_next;
    logic [CHAN_W-1:0] chan_idx_reg, chan_idx_next;
    logic              out_valid_reg;
    out_item_t         out_item_reg;

    logic [15:0] win_tick;
    logic [15:0] dwell_tick;
    logic [7:0]  need;
    logic        done;
    logic [15:0] count_out;
    logic        started;
    logic        stopped;
    logic        hopped;

    // saturating millisecond count
    function automatic logic [15:0] tick_up(input logic [15:0] t);
        return (t != COUNT_MAX) ? t + 16'd1 : COUNT_MAX;
    endfunction

    // take the next entry when the result register is free or draining
    assign pop       = ~q_status.empty & (~out_valid_reg | ~out_stall);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign win_tick   = tick_up(win_elapsed_reg);
    assign dwell_tick = tick_up(dwell_elapsed_reg);
    assign need       = (cfg.min_windows == 8'd0) ? 8'd1 : cfg.min_windows;

    // state update for one entry
    always_comb
    begin
        pkt_count_next     = pkt_count_reg;
        run_next           = run_reg;
        win_elapsed_next   = win_elapsed_reg;
        dwell_elapsed_next = dwell_elapsed_reg;
        chan_idx_next      = chan_idx_reg;
        done               = 1'b0;
        count_out          = '0;
        started            = 1'b0;
        stopped            = 1'b0;
        hopped             = 1'b0;
        if (pop)
        begin
            if (!head.is_tick)
            begin
                if (head.is_match && (pkt_count_reg != COUNT_MAX))
                begin
                    pkt_count_next = pkt_count_reg + 16'd1;
                end
            end
            else if (cfg.enable)
            begin
                // evaluation window
                if (win_tick >= cfg.window_ms)
                begin
                    win_elapsed_next = '0;
                    done             = 1'b1;
                    count_out        = pkt_count_reg;
                    pkt_count_next   = '0;
                    if (pkt_count_reg >= cfg.min_packets)
                    begin
                        if (run_reg != RUN_MAX)
                        begin
                            run_next = run_reg + 8'd1;
                            started  = ((run_reg + 8'd1) == need);
                        end
                    end
                    else
                    begin
                        stopped  = (run_reg >= need);
                        run_next = '0;
                    end
                end
                else
                begin
                    win_elapsed_next = win_tick;
                end
                // channel dwell
                if (NUM_CHANNELS > 1)
                begin
                    if (dwell_tick >= cfg.dwell_ms)
                    begin
                        dwell_elapsed_next = '0;
                        hopped             = 1'b1;
                        chan_idx_next      = (chan_idx_reg >= CHAN_W'(NUM_CHANNELS - 1)) ?
                                             '0 : chan_idx_reg + 1'b1;
                    end
                    else
                    begin
                        dwell_elapsed_next = dwell_tick;
                    end
                end
            end
        end
    end

    // detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_count_reg     <= '0;
            run_reg           <= '0;
            win_elapsed_reg   <= '0;
            dwell_elapsed_reg <= '0;
            chan_idx_reg      <= '0;
        end
        else
        begin
            pkt_count_reg     <= pkt_count_next;
            run_reg           <= run_next;
            win_elapsed_reg   <= win_elapsed_next;
            dwell_elapsed_reg <= dwell_elapsed_next;
            chan_idx_reg      <= chan_idx_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg.window_done         <= done;
            out_item_reg.window_packet_count <= count_out;
            out_item_reg.attack_run          <= run_next;
            out_item_reg.attack_onset        <= started;
            out_item_reg.attack_cleared      <= stopped;
            out_item_reg.channel_changed     <= hopped;
            out_item_reg.channel             <= chan_idx_next + 1'b1;
        end
    end

endmodule

// File: verif/deauth_attack_detector_unit_test.sv
// self-checking testbench for deauth_attack_detector_unit
// depends on dad_pkg and the detector rtl; frame and tick stream, apb register setup
module deauth_attack_detector_unit_test
    import dad_pkg::*;
();

    // command codes of an input transaction
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam int CYCLE_LIMIT = 100000;
    localparam int PRINT_LIMIT = 200;

    // result of any item while disabled and still on the first channel
    localparam out_item_t IDLE_RESULT = '{1'b0, 16'd0, 8'd0, 1'b0, 1'b0, 1'b0, 4'd1};

    // one row of the directed table: a register write or an input transaction
    typedef struct packed {
        logic                 write_cfg;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [15:0]          value;
        in_item_t             item;
        logic                 typed;
        out_item_t            want;
    } step_t;

    localparam step_t DIRECTED_STEPS [31] = '{
        // disabled: frames of every kind only feed the counter
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_FRAME, TYPE_DEAUTH, 16'd28}, 1'b1, IDLE_RESULT},
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_FRAME, TYPE_DISASSOC, 16'd65535}, 1'b1, IDLE_RESULT},
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_FRAME, TYPE_DEAUTH, 16'd27}, 1'b1, IDLE_RESULT},
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_FRAME, TYPE_DISASSOC, 16'd0}, 1'b1, IDLE_RESULT},
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_FRAME, 8'hFF, 16'd65535}, 1'b1, IDLE_RESULT},
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_FRAME, 8'h00, 16'd0}, 1'b1, IDLE_RESULT},
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_FRAME, 8'hA1, 16'd200}, 1'b1, IDLE_RESULT},
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_FRAME, 8'h20, 16'd28}, 1'b1, IDLE_RESULT},
        // disabled ticks leave timers frozen
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_TICK, 8'h00, 16'd0}, 1'b1, IDLE_RESULT},
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_TICK, 8'hFF, 16'd65535}, 1'b1, IDLE_RESULT},
        // short windows, fast hopping, two windows to start
        '{1'b1, REG_MIN_PACKETS, 16'd2, '0, 1'b0, '0},
        '{1'b1, REG_MIN_WINDOWS, 16'd2, '0, 1'b0, '0},
        '{1'b1, REG_DWELL_MS, 16'd1, '0, 1'b0, '0},
        '{1'b1, REG_WINDOW_MS, 16'd2, '0, 1'b0, '0},
        '{1'b1, REG_ENABLE, 16'd1, '0, 1'b0, '0},
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_TICK, 8'h00, 16'd0}, 1'b0, '0},
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_TICK, 8'h00, 16'd0}, 1'b0, '0},
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_FRAME, TYPE_DISASSOC, 16'd28}, 1'b0, '0},
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_FRAME, TYPE_DEAUTH, 16'd1000}, 1'b0, '0},
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_TICK, 8'h00, 16'd0}, 1'b0, '0},
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_TICK, 8'h00, 16'd0}, 1'b0, '0},
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_TICK, 8'h00, 16'd0}, 1'b0, '0},
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_TICK, 8'h00, 16'd0}, 1'b0, '0},
        // zero registers: every tick closes a window and hops, run of one starts
        '{1'b1, REG_MIN_WINDOWS, 16'd0, '0, 1'b0, '0},
        '{1'b1, REG_WINDOW_MS, 16'd0, '0, 1'b0, '0},
        '{1'b1, REG_DWELL_MS, 16'd0, '0, 1'b0, '0},
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_FRAME, TYPE_DEAUTH, 16'd28}, 1'b0, '0},
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_FRAME, TYPE_DISASSOC, 16'd28}, 1'b0, '0},
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_TICK, 8'h00, 16'd0}, 1'b0, '0},
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_TICK, 8'h00, 16'd0}, 1'b0, '0},
        '{1'b0, REG_ENABLE, 16'd0, '{CMD_TICK, 8'h00, 16'd0}, 1'b0, '0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_item;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // register copies
    logic        det_enable    = ENABLE_RST;
    logic [15:0] pkt_threshold = MIN_PACKETS_RST;
    logic [7:0]  run_threshold = MIN_WINDOWS_RST;
    logic [15:0] dwell_len     = DWELL_MS_RST;
    logic [15:0] window_len    = WINDOW_MS_RST;

    // detector state as predicted
    logic [15:0] frame_count      = '0;
    logic [7:0]  attacked_windows = '0;
    logic [15:0] window_elapsed   = '0;
    logic [15:0] dwell_elapsed    = '0;
    logic [3:0]  chan_index       = '0;

    out_item_t expected_results [$];
    int        mismatch_count = 0;
    int        result_count   = 0;
    int        cycle_count    = 0;
    bit        calm           = 1'b0;

    deauth_attack_detector_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 20 unit clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("deauth_attack_detector_unit: mismatch");
            $finish;
        end
    end

    // random stall on the result side
    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < 11);
    end

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("error: %s", what);
    endtask

    // next result of the detector for one accepted transaction; advances the state copy
    function automatic out_item_t predict_detector_result(in_item_t item);
        out_item_t  res;
        logic [7:0] run_needed;
        res = '0;
        run_needed = (run_threshold == 8'd0) ? 8'd1 : run_threshold;
        if (item.cmd == CMD_FRAME)
        begin
            // deauth or disassoc frames of full length count, even when disabled
            if (item.frame_length >= MIN_FRAME_LEN &&
                (item.frame_type_byte == TYPE_DEAUTH || item.frame_type_byte == TYPE_DISASSOC) &&
                frame_count != COUNT_MAX)
                frame_count++;
        end
        else if (det_enable)
        begin
            // window timer and attack run
            if (window_elapsed != 16'hFFFF)
                window_elapsed++;
            if (window_elapsed >= window_len)
            begin
                window_elapsed = '0;
                res.window_done = 1'b1;
                res.window_packet_count = frame_count;
                if (frame_count >= pkt_threshold)
                begin
                    if (attacked_windows != RUN_MAX)
                    begin
                        attacked_windows++;
                        res.attack_onset = (attacked_windows == run_needed);
                    end
                end
                else
                begin
                    res.attack_cleared = (attacked_windows >= run_needed);
                    attacked_windows = '0;
                end
                frame_count = '0;
            end
            // dwell timer and channel hop
            if (NUM_CHANNELS > 1)
            begin
                if (dwell_elapsed != 16'hFFFF)
                    dwell_elapsed++;
                if (dwell_elapsed >= dwell_len)
                begin
                    dwell_elapsed = '0;
                    res.channel_changed = 1'b1;
                    chan_index = (int'(chan_index) + 1 >= NUM_CHANNELS) ? 4'd0 : chan_index + 4'd1;
                end
            end
        end
        res.attack_run = attacked_windows;
        res.channel = chan_index + 4'd1;
        return res;
    endfunction

    task automatic compare_result(out_item_t got, out_item_t want);
        if (got.window_done !== want.window_done)
            report_mismatch($sformatf("result %0d window_done %h, expected %h",
                            result_count, got.window_done, want.window_done));
        if (got.window_packet_count !== want.window_packet_count)
            report_mismatch($sformatf("result %0d window_packet_count %h, expected %h",
                            result_count, got.window_packet_count, want.window_packet_count));
        if (got.attack_run !== want.attack_run)
            report_mismatch($sformatf("result %0d attack_run %h, expected %h",
                            result_count, got.attack_run, want.attack_run));
        if (got.attack_onset !== want.attack_onset)
            report_mismatch($sformatf("result %0d attack_onset %h, expected %h",
                            result_count, got.attack_onset, want.attack_onset));
        if (got.attack_cleared !== want.attack_cleared)
            report_mismatch($sformatf("result %0d attack_cleared %h, expected %h",
                            result_count, got.attack_cleared, want.attack_cleared));
        if (got.channel_changed !== want.channel_changed)
            report_mismatch($sformatf("result %0d channel_changed %h, expected %h",
                            result_count, got.channel_changed, want.channel_changed));
        if (got.channel !== want.channel)
            report_mismatch($sformatf("result %0d channel %h, expected %h",
                            result_count, got.channel, want.channel));
    endtask

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result %0d with no transaction outstanding",
                                result_count));
            else
                compare_result(out_item, expected_results.pop_front());
            result_count++;
        end
    end

    // one input transaction, with random idle cycles ahead of it
    task automatic send_item(in_item_t item, logic typed, out_item_t want);
        out_item_t predicted;
        while (!calm && $urandom_range(0, 99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = predict_detector_result(item);
        expected_results.push_back(typed ? want : predicted);
    endtask

    // hold off the input until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // apb setup and access phase, then a return to idle
    task automatic apb_access(logic wr, logic [REG_IDX_W-1:0] idx, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // register write, copy update and read back
    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [15:0] value);
        logic [31:0] readback;
        logic [31:0] stored;
        apb_access(1'b1, idx, {16'd0, value}, readback);
        stored = '0;
        case (idx)
            REG_ENABLE:
            begin
                det_enable = value[0];
                stored = {31'd0, value[0]};
            end
            REG_MIN_PACKETS:
            begin
                pkt_threshold = value;
                stored = {16'd0, value};
            end
            REG_MIN_WINDOWS:
            begin
                run_threshold = value[7:0];
                stored = {24'd0, value[7:0]};
            end
            REG_DWELL_MS:
            begin
                dwell_len = value;
                stored = {16'd0, value};
            end
            REG_WINDOW_MS:
            begin
                window_len = value;
                stored = {16'd0, value};
            end
            default:
            begin
                stored = '0;
            end
        endcase
        apb_access(1'b0, idx, 32'd0, readback);
        if (readback !== stored)
            report_mismatch($sformatf("register %0d reads %h, expected %h", idx, readback, stored));
    endtask

    // mostly ticks and matching frames, with runts and foreign frames as noise
    function automatic in_item_t random_item(int tick_pct);
        in_item_t item;
        int       pick;
        pick = $urandom_range(0, 99);
        item.cmd = CMD_FRAME;
        item.frame_type_byte = 8'($urandom);
        item.frame_length = 16'($urandom);
        if (pick < tick_pct)
            item.cmd = CMD_TICK;
        else if (pick < tick_pct + (100 - tick_pct) * 3 / 4)
        begin
            item.frame_type_byte = $urandom_range(0, 1) ? TYPE_DEAUTH : TYPE_DISASSOC;
            item.frame_length = 16'($urandom_range(28, 65535));
        end
        else if (pick[0])
        begin
            // right type but too short
            item.frame_type_byte = $urandom_range(0, 1) ? TYPE_DEAUTH : TYPE_DISASSOC;
            item.frame_length = 16'($urandom_range(0, 27));
        end
        return item;
    endfunction

    // new settings on an idle block, then a stretch of random transactions
    task automatic run_phase(logic en, logic [15:0] pkts, logic [7:0] runs, logic [15:0] dwell,
                             logic [15:0] window, int n_items, int tick_pct);
        drain_results();
        write_reg(REG_MIN_PACKETS, pkts);
        write_reg(REG_MIN_WINDOWS, {8'd0, runs});
        write_reg(REG_DWELL_MS, dwell);
        write_reg(REG_WINDOW_MS, window);
        write_reg(REG_ENABLE, {15'd0, en});
        for (int n = 0; n < n_items; n++)
            send_item(random_item(tick_pct), 1'b0, '0);
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < $size(DIRECTED_STEPS); i++)
        begin
            if (DIRECTED_STEPS[i].write_cfg)
            begin
                drain_results();
                write_reg(DIRECTED_STEPS[i].reg_idx, DIRECTED_STEPS[i].value);
            end
            else
                send_item(DIRECTED_STEPS[i].item, DIRECTED_STEPS[i].typed,
                          DIRECTED_STEPS[i].want);
        end

        // small random settings, one phase without any idling
        for (int p = 0; p < 4; p++)
        begin
            calm = (p == 1);
            run_phase(1'b1, 16'($urandom_range(1, 5)), 8'($urandom_range(0, 3)),
                      16'($urandom_range(1, 4)), 16'($urandom_range(1, 6)), 40, 45);
        end
        calm = 1'b0;

        // every tick an attacked window: run saturates past a start at 255
        run_phase(1'b1, 16'd0, 8'd255, 16'd3, 16'd1, 320, 95);
        // largest settings: nothing closes or hops
        run_phase(1'b1, 16'd65535, 8'd255, 16'd65535, 16'd65535, 40, 50);
        // every window closes on a tick of its own
        run_phase(1'b1, 16'd1, 8'd1, 16'd2, 16'd1, 40, 40);
        // disabled with random settings
        run_phase(1'b0, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 40, 50);

        drain_results();
        if (mismatch_count == 0)
            $display("deauth_attack_detector_unit: match");
        else
            $display("deauth_attack_detector_unit: mismatch");
        $finish;
    end

endmodule
